@@ sv/gbte_pkg.sv @@
// gap buffer editor package: command codes, field widths and types
`default_nettype none

package gbte_pkg;

    // command codes on the opcode field, code 7 is a no-op
    localparam logic [2:0] OP_INSERT    = 3'd0;
    localparam logic [2:0] OP_BACKSPACE = 3'd1;
    localparam logic [2:0] OP_LEFT      = 3'd2;
    localparam logic [2:0] OP_RIGHT     = 3'd3;
    localparam logic [2:0] OP_MOVE_TO   = 3'd4;
    localparam logic [2:0] OP_READ_AT   = 3'd5;
    localparam logic [2:0] OP_CLEAR     = 3'd6;
    localparam logic [2:0] OP_NOP       = 3'd7;

    // widths of the external fields
    localparam int OPCODE_W = 3;
    localparam int CHAR_W   = 8;
    localparam int POS_W    = 13;

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [OPCODE_W-1:0] t_opcode;

endpackage

`default_nettype wire

@@ sv/gbte_ram.sv @@
// generic simple dual port ram with registered read
`default_nettype none

module gbte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic                       i_re,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic      [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ sv/gap_buffer_text_editor.sv @@
// gap buffer text editor top level: command sequencer around the text ram
//
//  channel   direction  handshake                    payload
//  command   in         i_in_valid / o_in_stall      i_opcode, i_char_in, i_position
//  result    out        o_out_valid / i_out_stall    o_char_out, o_cursor, o_text_length,
//                                                    o_dropped, o_modified
//
//  insert, backspace, clear, the no-op and an out-of-range read_at pass through
//  S_EXEC and S_DONE from transfer to result
//  read_at within the length adds S_READ for the registered ram read
//  left, right and move_to pass through S_MOVE and S_SHIFT once per byte walked across the gap;
//  each byte is one ram read then one ram write on the single text ram
//  reset (synchronous, active low) empties the buffer; the ram itself is not cleared
//  a command is taken only when the sequencer is idle; a stalled result waits in
//  the output register while the next command already runs
`default_nettype none

module gap_buffer_text_editor #(
    parameter int CAPACITY = 4096
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire gbte_pkg::t_opcode    i_opcode,
    input  wire gbte_pkg::t_char      i_char_in,
    input  wire gbte_pkg::t_pos       i_position,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output gbte_pkg::t_char           o_char_out,
    output gbte_pkg::t_pos            o_cursor,
    output gbte_pkg::t_pos            o_text_length,
    output logic                      o_dropped,
    output logic                      o_modified
);

    import gbte_pkg::*;

    // address width of the store, counter width able to hold CAPACITY itself
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    // common width for comparing counters with the 13 bit position field
    localparam int EW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MOVE,
        S_SHIFT,
        S_READ,
        S_DONE
    } t_state;

    t_state        r_state;

    // gap pointers and dirty mark
    logic [CW-1:0] r_gs;
    logic [CW-1:0] r_ge;
    logic          r_dirty;

    // latched command
    t_opcode       r_op;
    t_char         r_ch;
    t_pos          r_pos;

    // walk target for left, right and move_to
    logic [CW-1:0] r_target;

    // result staging
    t_char         r_char;
    logic          r_drop;

    // output register
    logic          r_out_valid;
    t_char         r_out_char;
    t_pos          r_out_cursor;
    t_pos          r_out_len;
    logic          r_out_drop;
    logic          r_out_mod;

    // ram ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_char         ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    t_char         ram_rdata;

    // derived values
    logic [CW-1:0] gap_w;
    logic [CW-1:0] len;
    logic [EW-1:0] pos_e;
    logic [EW-1:0] len_e;
    logic [EW-1:0] gs_e;
    logic [CW-1:0] pos_c;
    logic [CW-1:0] clamp_pos;
    logic [CW-1:0] gs_dec;
    logic [CW-1:0] ge_dec;
    logic [CW-1:0] read_idx;
    logic          walk_left;
    logic          out_free;

    assign gap_w     = r_ge - r_gs;
    assign len       = CAP_C - gap_w;
    assign pos_e     = EW'(r_pos);
    assign len_e     = EW'(len);
    assign gs_e      = EW'(r_gs);
    assign pos_c     = CW'(r_pos);
    // pos fits in CW bits whenever it is not beyond the length
    assign clamp_pos = (pos_e > len_e) ? len : pos_c;
    assign gs_dec    = r_gs - ONE_C;
    assign ge_dec    = r_ge - ONE_C;
    // logical index to physical, skipping the gap when past the cursor
    assign read_idx  = (pos_e < gs_e) ? pos_c : (pos_c + gap_w);
    assign walk_left = (r_gs > r_target);
    // the output register can take a new result this cycle
    assign out_free  = !r_out_valid || !i_out_stall;

    assign o_in_stall = (r_state != S_IDLE);

    // ram access per state
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_gs[AW-1:0];
        ram_wdata = r_ch;
        ram_re    = 1'b0;
        ram_raddr = read_idx[AW-1:0];
        case (r_state)
            S_EXEC: begin
                if (r_op == OP_INSERT && r_gs != r_ge) begin
                    ram_we = 1'b1;
                end
                if (r_op == OP_READ_AT && pos_e < len_e) begin
                    ram_re = 1'b1;
                end
            end
            S_MOVE: begin
                // fetch the byte next to the gap on the walk side
                if (r_gs != r_target) begin
                    ram_re    = 1'b1;
                    ram_raddr = walk_left ? gs_dec[AW-1:0] : r_ge[AW-1:0];
                end
            end
            S_SHIFT: begin
                // drop it on the other side of the gap
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                ram_waddr = walk_left ? ge_dec[AW-1:0] : r_gs[AW-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gs        <= '0;
            r_ge        <= CAP_C;
            r_dirty     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // a waiting result leaves on its transfer; in S_DONE a new one replaces it
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_opcode;
                        r_ch    <= i_char_in;
                        r_pos   <= i_position;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_char <= '0;
                    r_drop <= (r_op == OP_INSERT) && (r_gs == r_ge);
                    case (r_op)
                        OP_INSERT: begin
                            if (r_gs != r_ge) begin
                                r_gs    <= r_gs + ONE_C;
                                r_dirty <= 1'b1;
                            end
                            r_state <= S_DONE;
                        end
                        OP_BACKSPACE: begin
                            if (r_gs != '0) begin
                                r_gs    <= gs_dec;
                                r_dirty <= 1'b1;
                            end
                            r_state <= S_DONE;
                        end
                        OP_LEFT: begin
                            // one byte left, none at the start
                            r_target <= (r_gs != '0) ? gs_dec : r_gs;
                            r_state  <= S_MOVE;
                        end
                        OP_RIGHT: begin
                            // one byte right, none at the end
                            r_target <= (r_ge != CAP_C) ? (r_gs + ONE_C) : r_gs;
                            r_state  <= S_MOVE;
                        end
                        OP_MOVE_TO: begin
                            r_target <= clamp_pos;
                            r_state  <= S_MOVE;
                        end
                        OP_READ_AT: begin
                            if (pos_e < len_e) begin
                                r_state <= S_READ;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        OP_CLEAR: begin
                            r_gs    <= '0;
                            r_ge    <= CAP_C;
                            r_dirty <= 1'b0;
                            r_state <= S_DONE;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_MOVE: begin
                    if (r_gs == r_target) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (walk_left) begin
                        r_gs <= gs_dec;
                        r_ge <= ge_dec;
                    end else begin
                        r_gs <= r_gs + ONE_C;
                        r_ge <= r_ge + ONE_C;
                    end
                    r_state <= S_MOVE;
                end
                S_READ: begin
                    r_char  <= ram_rdata;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_char   <= r_char;
                        r_out_cursor <= gs_e[POS_W-1:0];
                        r_out_len    <= len_e[POS_W-1:0];
                        r_out_drop   <= r_drop;
                        r_out_mod    <= r_dirty;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    gbte_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CAPACITY)
    ) u_text_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid   = r_out_valid;
    assign o_char_out    = r_out_char;
    assign o_cursor      = r_out_cursor;
    assign o_text_length = r_out_len;
    assign o_dropped     = r_out_drop;
    assign o_modified    = r_out_mod;

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// testbench for the gap buffer text editor: directed table and random edits
`timescale 1ns / 100ps

module tb;
    import gbte_pkg::*;

    localparam int CAP          = 4096;
    localparam int RANDOM_ITEMS = 820;
    localparam int MAX_REPORTS  = 10;
    // worst silent stretch: a move_to across the whole store (a ram read and a ram write a byte)
    // plus a long receiver hold-off, taken several times over
    localparam int IDLE_LIMIT   = 40000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        t_char ch;
        t_pos  cur;
        t_pos  len;
        logic  drop;
        logic  mod;
    } edit_result_t;

    typedef struct {
        t_opcode      op;
        t_char        ch;
        t_pos         pos;
        bit           fixed;
        edit_result_t res;
    } cmd_row_t;

    logic    i_clk;
    logic    i_rst_n;
    logic    i_in_valid;
    logic    o_in_stall;
    t_opcode i_opcode;
    t_char   i_char_in;
    t_pos    i_position;
    logic    o_out_valid;
    logic    i_out_stall;
    t_char   o_char_out;
    t_pos    o_cursor;
    t_pos    o_text_length;
    logic    o_dropped;
    logic    o_modified;

    gap_buffer_text_editor #(
        .CAPACITY(CAP)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_char_in    (i_char_in),
        .i_position   (i_position),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_char_out   (o_char_out),
        .o_cursor     (o_cursor),
        .o_text_length(o_text_length),
        .o_dropped    (o_dropped),
        .o_modified   (o_modified)
    );

    // mirror of the editor state
    t_char text_mem [CAP];
    int    gap_lo;
    int    gap_hi;
    logic  dirty_q;

    edit_result_t pending_results[$];
    cmd_row_t     cmd_table[$];

    int  mismatch_count;
    int  results_seen;
    int  idle_cycles;
    bit  no_idle;
    bit  long_hold;

    int      random_items;
    int      burst_len;
    int      pick;
    int      cur_len;
    t_opcode rnd_op;
    t_pos    rnd_pos;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int text_len();
        return CAP - (gap_hi - gap_lo);
    endfunction

    function automatic void step_left();
        if (gap_lo > 0) begin
            gap_hi--;
            gap_lo--;
            text_mem[gap_hi] = text_mem[gap_lo];
        end
    endfunction

    function automatic void step_right();
        if (gap_hi < CAP) begin
            text_mem[gap_lo] = text_mem[gap_hi];
            gap_lo++;
            gap_hi++;
        end
    endfunction

    // runs one command on the mirror and returns the result it should give
    function automatic edit_result_t edit_apply(t_opcode op, t_char ch, t_pos pos);
        edit_result_t r;
        int target;
        r = '0;
        case (op)
            OP_INSERT: begin
                if (gap_lo == gap_hi) begin
                    r.drop = 1'b1;
                end else begin
                    text_mem[gap_lo] = ch;
                    gap_lo++;
                    dirty_q = 1'b1;
                end
            end
            OP_BACKSPACE: begin
                if (gap_lo > 0) begin
                    gap_lo--;
                    dirty_q = 1'b1;
                end
            end
            OP_LEFT:  step_left();
            OP_RIGHT: step_right();
            OP_MOVE_TO: begin
                target = pos;
                if (target > text_len()) target = text_len();
                while (gap_lo > target) step_left();
                while (gap_lo < target) step_right();
            end
            OP_READ_AT: begin
                if (pos < text_len()) begin
                    if (pos < gap_lo) r.ch = text_mem[pos];
                    else r.ch = text_mem[pos + gap_hi - gap_lo];
                end
            end
            OP_CLEAR: begin
                gap_lo  = 0;
                gap_hi  = CAP;
                dirty_q = 1'b0;
            end
            default: ;
        endcase
        r.cur = gap_lo[POS_W-1:0];
        r.len = t_pos'(text_len());
        r.mod = dirty_q;
        return r;
    endfunction

    function automatic int draw_wait();
        if (no_idle || long_hold) return 0;
        return $urandom_range(0, 19);
    endfunction

    // table row; the typed result only covers char_out 0 and dropped 0
    task automatic add_row(t_opcode op, t_char ch, t_pos pos, bit fixed,
                           t_pos e_cur, t_pos e_len, logic e_mod);
        cmd_row_t row;
        row.op    = op;
        row.ch    = ch;
        row.pos   = pos;
        row.fixed = fixed;
        row.res   = '{ch: '0, cur: e_cur, len: e_len, drop: 1'b0, mod: e_mod};
        cmd_table.push_back(row);
    endtask

    // offers one command and holds it until the transfer, then predicts its result
    task automatic send_cmd(t_opcode op, t_char ch, t_pos pos, bit fixed,
                            edit_result_t fixed_res);
        int gap;
        edit_result_t res;
        gap = draw_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_char_in  <= ch;
        i_position <= pos;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        res = edit_apply(op, ch, pos);
        if (fixed) pending_results.push_back(fixed_res);
        else pending_results.push_back(res);
    endtask

    task automatic send_rnd(t_opcode op, t_pos pos);
        send_cmd(op, t_char'($urandom_range(0, 255)), pos, 1'b0, '0);
    endtask

    // result side: random stall per result, two long hold-offs, field check
    initial begin
        int stall_len;
        edit_result_t got;
        edit_result_t want;
        i_out_stall = 1'b0;
        forever begin
            if (results_seen == 60 || results_seen == 500) begin
                // hold off long enough that the command side backs up and stalls
                long_hold = 1'b1;
                stall_len = HOLD_CYCLES;
            end else begin
                stall_len = draw_wait();
            end
            if (stall_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (stall_len) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            long_hold = 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            got = '{ch: o_char_out, cur: o_cursor, len: o_text_length,
                    drop: o_dropped, mod: o_modified};
            if (pending_results.size() == 0) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected result: char %h cursor %0d length %0d %s %b %s %b",
                             got.ch, got.cur, got.len, "dropped", got.drop,
                             "modified", got.mod);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    if (mismatch_count < MAX_REPORTS)
                        $display({"result %0d mismatch (expected/actual): char %h/%h ",
                                  "cursor %0d/%0d length %0d/%0d dropped %b/%b ",
                                  "modified %b/%b"},
                                 results_seen, want.ch, got.ch, want.cur, got.cur,
                                 want.len, got.len, want.drop, got.drop,
                                 want.mod, got.mod);
                    mismatch_count++;
                end
            end
            results_seen++;
        end
    end

    // watchdog: cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
                     (o_out_valid === 1'b1 && i_out_stall === 1'b0)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_opcode       = OP_INSERT;
        i_char_in      = '0;
        i_position     = '0;
        gap_lo         = 0;
        gap_hi         = CAP;
        dirty_q        = 1'b0;
        mismatch_count = 0;
        results_seen   = 0;
        no_idle        = 1'b0;
        long_hold      = 1'b0;
        random_items   = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part: empty-buffer corners, a short edit, out-of-range reads, clear
        add_row(OP_READ_AT,   8'h00, 13'd0,    1, 13'd0, 13'd0, 1'b0);
        add_row(OP_BACKSPACE, 8'h00, 13'd0,    1, 13'd0, 13'd0, 1'b0); // at start, mark stays
        add_row(OP_LEFT,      8'h00, 13'd0,    1, 13'd0, 13'd0, 1'b0);
        add_row(OP_RIGHT,     8'h00, 13'd0,    1, 13'd0, 13'd0, 1'b0);
        add_row(OP_MOVE_TO,   8'h00, 13'h1FFF, 1, 13'd0, 13'd0, 1'b0); // clamps to empty
        add_row(OP_NOP,       8'hFF, 13'h1FFF, 1, 13'd0, 13'd0, 1'b0); // unused code
        add_row(OP_INSERT,    8'hFF, 13'h1FFF, 1, 13'd1, 13'd1, 1'b1);
        add_row(OP_INSERT,    8'h00, 13'd0,    1, 13'd2, 13'd2, 1'b1);
        add_row(OP_INSERT,    8'hA5, 13'd0,    0, '0, '0, 1'b0);
        add_row(OP_INSERT,    8'h5A, 13'd0,    0, '0, '0, 1'b0);
        add_row(OP_LEFT,      8'h00, 13'd0,    0, '0, '0, 1'b0);
        add_row(OP_LEFT,      8'h00, 13'd0,    0, '0, '0, 1'b0);
        add_row(OP_READ_AT,   8'h00, 13'd0,    0, '0, '0, 1'b0);
        add_row(OP_READ_AT,   8'h00, 13'd3,    0, '0, '0, 1'b0); // after the gap
        add_row(OP_READ_AT,   8'h00, 13'd4,    0, '0, '0, 1'b0); // index equal to length
        add_row(OP_READ_AT,   8'h00, 13'h1FFF, 1, 13'd2, 13'd4, 1'b1);
        add_row(OP_RIGHT,     8'h00, 13'd0,    0, '0, '0, 1'b0);
        add_row(OP_BACKSPACE, 8'h00, 13'd0,    0, '0, '0, 1'b0);
        add_row(OP_MOVE_TO,   8'h00, 13'd0,    0, '0, '0, 1'b0);
        add_row(OP_MOVE_TO,   8'h00, 13'h1FFF, 0, '0, '0, 1'b0); // clamps to length
        add_row(OP_INSERT,    8'h80, 13'd0,    0, '0, '0, 1'b0);
        add_row(OP_MOVE_TO,   8'h00, 13'd1,    0, '0, '0, 1'b0);
        add_row(OP_READ_AT,   8'h00, 13'd2,    0, '0, '0, 1'b0);
        add_row(OP_CLEAR,     8'h00, 13'd0,    1, 13'd0, 13'd0, 1'b0);
        add_row(OP_READ_AT,   8'h00, 13'd0,    1, 13'd0, 13'd0, 1'b0);
        foreach (cmd_table[i])
            send_cmd(cmd_table[i].op, cmd_table[i].ch, cmd_table[i].pos,
                     cmd_table[i].fixed, cmd_table[i].res);

        // random part: mostly typing bursts, some raw noise on every field
        while (random_items < RANDOM_ITEMS) begin
            no_idle = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            if (text_len() > 400) begin
                send_rnd(OP_CLEAR, t_pos'($urandom_range(0, 8191)));
                random_items++;
            end else if (pick < 70) begin
                burst_len = $urandom_range(5, 40);
                repeat (burst_len) begin
                    cur_len = text_len();
                    pick = $urandom_range(0, 99);
                    rnd_pos = t_pos'($urandom_range(0, 8191));
                    if (pick < 50) begin
                        rnd_op = OP_INSERT;
                    end else if (pick < 60) begin
                        rnd_op = OP_BACKSPACE;
                    end else if (pick < 68) begin
                        rnd_op = OP_LEFT;
                    end else if (pick < 76) begin
                        rnd_op = OP_RIGHT;
                    end else if (pick < 84) begin
                        rnd_op  = OP_MOVE_TO;
                        rnd_pos = t_pos'($urandom_range(0, cur_len + 3));
                    end else if (pick < 98) begin
                        rnd_op  = OP_READ_AT;
                        rnd_pos = t_pos'($urandom_range(0, cur_len + 2));
                    end else begin
                        rnd_op = OP_CLEAR;
                    end
                    send_rnd(rnd_op, rnd_pos);
                    random_items++;
                end
            end else begin
                burst_len = $urandom_range(3, 15);
                repeat (burst_len) begin
                    rnd_op = t_opcode'($urandom_range(0, 7));
                    send_rnd(rnd_op, t_pos'($urandom_range(0, 8191)));
                    random_items++;
                end
            end
        end
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/gbte_pkg.sv
sv/gbte_ram.sv
sv/gap_buffer_text_editor.sv
verif/tb.sv
